### rtl/fcsg_pkg.sv
// Package for the filled circle span generator.
// Widths, register codes and the circle job type shared by all modules.
// No dependencies.
package fcsg_pkg;

   localparam int COORD_W   = 14;
   localparam int CFG_W     = 11;
   localparam int POS_W     = 12;
   localparam int RAD_W     = 4;
   localparam int STEP_W    = 6;
   localparam int DEC_W     = 7;
   localparam int CALC_W    = 9;
   localparam int MAX_SPANS = 64;
   localparam int MAX_STEPS = MAX_SPANS / 4;
   localparam int CNT_W     = $clog2(MAX_STEPS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_W-1:0] SCR_COL_RESET = CFG_W'(640);
   localparam logic [CFG_W-1:0] SCR_ROW_RESET = CFG_W'(360);

   typedef enum logic [0:0] {
      CSR_SCR_COL = 1'b0,
      CSR_SCR_ROW = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [RAD_W-1:0]          radius;
   } job_type;

endpackage

### rtl/fcsg_front.sv
// Front end: origin registers, request acceptance and circle set-up.
// Depends on fcsg_pkg.
module fcsg_front #(
   parameter int MAX_RADIUS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  fcsg_pkg::csr_index_type       csr_index,
   input  logic [fcsg_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [fcsg_pkg::POS_W-1:0] req_center_x,
   input  logic signed [fcsg_pkg::POS_W-1:0] req_center_y,
   input  logic [fcsg_pkg::RAD_W-1:0]    req_radius,
   output logic                          push,
   input  logic                          full,
   output fcsg_pkg::job_type             push_job
);
   import fcsg_pkg::*;

   logic [CFG_W-1:0] scr_col_ff, scr_col_in;
   logic [CFG_W-1:0] scr_row_ff, scr_row_in;
   logic signed [COORD_W-1:0] org_x, org_y, cen_x, cen_y;

   assign csr_ready = 1'b1;

   always_comb begin
      scr_col_in = scr_col_ff;
      scr_row_in = scr_row_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SCR_COL: scr_col_in = csr_wdata;
            CSR_SCR_ROW: scr_row_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_col_ff <= SCR_COL_RESET;
         scr_row_ff <= SCR_ROW_RESET;
      end else begin
         scr_col_ff <= scr_col_in;
         scr_row_ff <= scr_row_in;
      end
   end

   assign org_x = signed'({{(COORD_W-CFG_W){1'b0}}, scr_col_ff});
   assign org_y = signed'({{(COORD_W-CFG_W){1'b0}}, scr_row_ff});
   assign cen_x = signed'({{(COORD_W-POS_W){req_center_x[POS_W-1]}}, req_center_x});
   assign cen_y = signed'({{(COORD_W-POS_W){req_center_y[POS_W-1]}}, req_center_y});

   assign req_ready = !full;
   assign push      = req_valid && !full;

   always_comb begin
      push_job.cx = org_x + cen_x;
      push_job.cy = org_y - cen_y;
      if (req_radius > RAD_W'(MAX_RADIUS)) begin
         push_job.radius = RAD_W'(MAX_RADIUS);
      end else begin
         push_job.radius = req_radius;
      end
   end

endmodule

### rtl/fcsg_queue.sv
// Two-entry queue of circle jobs between front and back ends.
// Depends on fcsg_pkg.
module fcsg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fcsg_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output fcsg_pkg::job_type pop_job
);
   import fcsg_pkg::*;

   job_type mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/fcsg_back.sv
// Back end: circle recurrence stepping and span output register.
// Depends on fcsg_pkg.
module fcsg_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               empty,
   input  fcsg_pkg::job_type                  pop_job,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [fcsg_pkg::COORD_W-1:0] rsp_x_left,
   output logic signed [fcsg_pkg::COORD_W-1:0] rsp_x_right,
   output logic signed [fcsg_pkg::COORD_W-1:0] rsp_row_y,
   output logic                               rsp_last
);
   import fcsg_pkg::*;

   localparam logic signed [CALC_W-1:0] STEP_ONE = CALC_W'(1);

   logic                      busy_ff, busy_in;
   logic signed [STEP_W-1:0]  x_ff, x_in;
   logic signed [STEP_W-1:0]  y_ff, y_in;
   logic signed [DEC_W-1:0]   d_ff, d_in;
   logic [RAD_W-1:0]          r_ff, r_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [1:0]                idx_ff, idx_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic                      valid_ff, valid_in;
   logic signed [COORD_W-1:0] left_ff, left_in, right_ff, right_in, row_ff, row_in;
   logic                      last_ff, last_in;

   logic                      adv;
   logic signed [CALC_W-1:0]  xs, ys, ds, rs, nx, ny, nd;
   logic signed [CALC_W-1:0]  tx, ty, tr;
   logic signed [COORD_W-1:0] hx, hy, half, roff;
   logic                      more;

   assign adv = !valid_ff || rsp_ready;
   assign pop = !busy_ff && !empty;

   assign xs = CALC_W'(x_ff);
   assign ys = CALC_W'(y_ff);
   assign ds = CALC_W'(d_ff);
   assign rs = signed'({{(CALC_W-RAD_W){1'b0}}, r_ff});
   assign hx = COORD_W'(x_ff);
   assign hy = COORD_W'(y_ff);

   assign tx = xs + xs;
   assign ty = ys + ys;
   assign tr = (rs - ys) + (rs - ys);

   always_comb begin
      if (ds >= tx) begin
         nd = ds - tx - STEP_ONE;
         nx = xs + STEP_ONE;
         ny = ys;
      end else if (ds < tr) begin
         nd = ds + ty - STEP_ONE;
         nx = xs;
         ny = ys - STEP_ONE;
      end else begin
         nd = ds + ty - tx - STEP_ONE - STEP_ONE;
         nx = xs + STEP_ONE;
         ny = ys - STEP_ONE;
      end
      more = (ny >= nx) && (cnt_ff != CNT_W'(MAX_STEPS - 1));
   end

   always_comb begin
      case (idx_ff)
         2'd0: begin half = hy; roff = hx; end
         2'd1: begin half = hx; roff = hy; end
         2'd2: begin half = hx; roff = -hy; end
         2'd3: begin half = hy; roff = -hx; end
         default: begin half = hy; roff = hx; end
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      r_in     = r_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      valid_in = valid_ff;
      left_in  = left_ff;
      right_in = right_ff;
      row_in   = row_ff;
      last_in  = last_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         busy_in = 1'b1;
         x_in    = '0;
         y_in    = signed'({{(STEP_W-RAD_W){1'b0}}, pop_job.radius});
         d_in    = signed'({{(DEC_W-RAD_W){1'b0}}, pop_job.radius}) - DEC_W'(1);
         r_in    = pop_job.radius;
         cnt_in  = '0;
         idx_in  = '0;
         cx_in   = pop_job.cx;
         cy_in   = pop_job.cy;
      end else if (busy_ff && adv) begin
         valid_in = 1'b1;
         left_in  = cx_ff - half;
         right_in = cx_ff + half;
         row_in   = cy_ff + roff;
         last_in  = (idx_ff == 2'd3) && !more;
         idx_in   = idx_ff + 1'b1;
         if (idx_ff == 2'd3) begin
            x_in   = STEP_W'(nx);
            y_in   = STEP_W'(ny);
            d_in   = DEC_W'(nd);
            cnt_in = cnt_ff + 1'b1;
            busy_in = more;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         x_ff     <= '0;
         y_ff     <= '0;
         d_ff     <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         d_ff     <= d_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff     <= r_in;
      cnt_ff   <= cnt_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      row_ff   <= row_in;
      last_ff  <= last_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_x_left  = left_ff;
   assign rsp_x_right = right_ff;
   assign rsp_row_y   = row_ff;
   assign rsp_last    = last_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> !busy_ff)
      else $error("job popped while a circle is in progress");

   a_idx_busy: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> busy_ff)
      else $error("span index left mid-step while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && adv && (idx_ff == 2'd3) && !more) |=> (!busy_ff && rsp_valid && rsp_last))
      else $error("final span did not end the circle");

   a_x_le_y: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !pop) |-> (x_ff <= y_ff))
      else $error("recurrence stepped past the octant");

endmodule

### rtl/filled_circle_span_generator.sv
// Filled circle span generator, top level.
// Instantiates fcsg_front, fcsg_queue and fcsg_back; depends on fcsg_pkg.
//
// Usage:
//   req_*  : one request per circle (centre in world units, y up, radius).
//   rsp_*  : horizontal spans in screen units, four per recurrence step in
//            the order +x row, +y row, -y row, -x row; rsp_last marks the
//            final span of a circle.
//   csr_*  : writes the origin column (index 0) and origin row (index 1);
//            always ready. Write only while the block is idle.
// Flow: the back end pops a circle, then gives four spans for each of its S
//   recurrence steps (at most 16; about 11 for radius 15), since the one
//   recurrence unit produces one span per cycle while rsp_ready does not stall
//   it. A first span passes the queue, the pop and the span output register.
// The front end accepts up to two queued circles while the back end works.
// Reset: origins return to 640 and 360, the queue empties, no span pending.
// Receiver stall: the span is held in the output register, stepping stops,
//   and req_ready drops once the queue is full.
module filled_circle_span_generator #(
   parameter int MAX_RADIUS = 15
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  fcsg_pkg::csr_index_type            csr_index,
   input  logic [fcsg_pkg::CFG_W-1:0]         csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [fcsg_pkg::POS_W-1:0]  req_center_x,
   input  logic signed [fcsg_pkg::POS_W-1:0]  req_center_y,
   input  logic [fcsg_pkg::RAD_W-1:0]         req_radius,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [fcsg_pkg::COORD_W-1:0] rsp_x_left,
   output logic signed [fcsg_pkg::COORD_W-1:0] rsp_x_right,
   output logic signed [fcsg_pkg::COORD_W-1:0] rsp_row_y,
   output logic                               rsp_last
);
   import fcsg_pkg::*;

   logic    push, full, pop, empty;
   job_type push_job, pop_job;

   fcsg_front #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .push         (push),
      .full         (full),
      .push_job     (push_job)
   );

   fcsg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .pop_job  (pop_job)
   );

   fcsg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (empty),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_x_left  (rsp_x_left),
      .rsp_x_right (rsp_x_right),
      .rsp_row_y   (rsp_row_y),
      .rsp_last    (rsp_last)
   );

endmodule
